// ----- hw/rtl/cdq_pkg.sv -----
package cdq_pkg;

   localparam int DEPTH_DEFAULT = 8;
   localparam int DATA_W        = 32;
   localparam int KIND_W        = 2;
   localparam int STATUS_W      = 2;
   localparam int OCC_W         = 4;

   typedef enum logic [KIND_W-1:0] {
      REQ_PUSH_FRONT = 2'd0,
      REQ_PUSH_REAR  = 2'd1,
      REQ_POP_FRONT  = 2'd2,
      REQ_POP_REAR   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_RESP = 1'b1
   } fsm_type;

endpackage

// ----- hw/rtl/cdq_if.sv -----
interface cdq_req_if;
   logic                                      valid;
   logic                                      ready;
   logic        [cdq_pkg::KIND_W-1:0]         req_type;
   logic signed [cdq_pkg::DATA_W-1:0]         push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface cdq_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic        [cdq_pkg::STATUS_W-1:0]       status;
   logic        [cdq_pkg::OCC_W-1:0]          occupancy;
   logic                                      is_empty;
   logic                                      is_full;
   logic signed [cdq_pkg::DATA_W-1:0]         front_value;
   logic signed [cdq_pkg::DATA_W-1:0]         rear_value;

   modport source (output valid, output status, output occupancy, output is_empty,
                   output is_full, output front_value, output rear_value, input ready);
   modport sink   (input valid, input status, input occupancy, input is_empty,
                   input is_full, input front_value, input rear_value, output ready);
endinterface

// ----- hw/rtl/circular_deque_core.sv -----
// channel   dir   handshake          payload
// req_ch    in    valid / ready      req_type, push_value
// rsp_ch    out   valid / ready      status, occupancy, is_empty, is_full,
//                                    front_value, rear_value
//
// in its accept cycle in S_IDLE, each request updates the pointers, writes the slot
// memory and reads both end slots; the response register is then loaded in S_RESP.
// the slot memory has one write port and two registered read ports; a slot just
// written is forwarded to the response instead of the stale read data.
// reset empties the deque at once; slot contents are not cleared.
// a response held by rsp_ch stalls the block in S_RESP; a new request is
// taken while the previous response still waits.
module circular_deque_core #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   cdq_req_if.sink          req_ch,
   cdq_rsp_if.source        rsp_ch
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic signed [cdq_pkg::DATA_W-1:0] mem [DEPTH];

   cdq_pkg::fsm_type state_ff, state_in;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             empty_ff, empty_in;

   logic signed [cdq_pkg::DATA_W-1:0] rd_front_ff, rd_rear_ff;
   logic signed [cdq_pkg::DATA_W-1:0] push_val_ff;
   logic                              fwd_front_ff, fwd_rear_ff;
   cdq_pkg::status_type               status_ff, status_in;

   logic                              rsp_valid_ff;
   cdq_pkg::status_type               rsp_status_ff;
   logic [cdq_pkg::OCC_W-1:0]         rsp_occ_ff;
   logic                              rsp_empty_ff, rsp_full_ff;
   logic signed [cdq_pkg::DATA_W-1:0] rsp_front_ff, rsp_rear_ff;

   cdq_pkg::req_kind_type kind;
   logic                  accept;
   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic                  full_now;
   logic                  rsp_free;
   logic                  rsp_load;

   assign kind     = cdq_pkg::req_kind_type'(req_ch.req_type);
   assign accept   = req_ch.valid && req_ch.ready;
   assign full_now = (count_ff == CNT_FULL);
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cdq_pkg::S_IDLE: begin
            if (req_ch.valid) state_in = cdq_pkg::S_RESP;
         end
         cdq_pkg::S_RESP: begin
            if (rsp_free) state_in = cdq_pkg::S_IDLE;
         end
         default: state_in = cdq_pkg::S_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ch.ready = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         cdq_pkg::S_IDLE: req_ch.ready = 1'b1;
         cdq_pkg::S_RESP: rsp_load = rsp_free;
         default: begin
            req_ch.ready = 1'b0;
            rsp_load     = 1'b0;
         end
      endcase
   end

   // pointer update
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      empty_in  = empty_ff;
      status_in = cdq_pkg::ST_DONE;
      wr_en     = 1'b0;
      wr_addr   = head_ff;
      case (kind)
         cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_REAR: begin
            if (full_now) begin
               status_in = cdq_pkg::ST_FULL;
            end else if (empty_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
               count_in = CNT_W'(1);
               wr_en    = 1'b1;
               wr_addr  = '0;
            end else if (kind == cdq_pkg::REQ_PUSH_FRONT) begin
               head_in  = (head_ff == '0) ? PTR_LAST : head_ff - PTR_W'(1);
               count_in = count_ff + CNT_W'(1);
               wr_en    = 1'b1;
               wr_addr  = head_in;
            end else begin
               tail_in  = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
               count_in = count_ff + CNT_W'(1);
               wr_en    = 1'b1;
               wr_addr  = tail_in;
            end
         end
         cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_REAR: begin
            if (empty_ff) begin
               status_in = cdq_pkg::ST_EMPTY;
            end else if (head_ff == tail_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b1;
               count_in = '0;
            end else if (kind == cdq_pkg::REQ_POP_FRONT) begin
               head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
               count_in = count_ff - CNT_W'(1);
            end else begin
               tail_in  = (tail_ff == '0) ? PTR_LAST : tail_ff - PTR_W'(1);
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: status_in = cdq_pkg::ST_DONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdq_pkg::S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
            empty_ff <= empty_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         mem[wr_addr] <= req_ch.push_value;
      end
      if (accept) begin
         rd_front_ff <= mem[head_in];
         rd_rear_ff  <= mem[tail_in];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         push_val_ff  <= req_ch.push_value;
         fwd_front_ff <= wr_en && (wr_addr == head_in);
         fwd_rear_ff  <= wr_en && (wr_addr == tail_in);
         status_ff    <= status_in;
      end
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_occ_ff    <= cdq_pkg::OCC_W'(count_ff);
         rsp_empty_ff  <= empty_ff;
         rsp_full_ff   <= (count_ff == CNT_FULL);
         rsp_front_ff  <= empty_ff ? '0 : (fwd_front_ff ? push_val_ff : rd_front_ff);
         rsp_rear_ff   <= empty_ff ? '0 : (fwd_rear_ff ? push_val_ff : rd_rear_ff);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.occupancy   = rsp_occ_ff;
   assign rsp_ch.is_empty    = rsp_empty_ff;
   assign rsp_ch.is_full     = rsp_full_ff;
   assign rsp_ch.front_value = rsp_front_ff;
   assign rsp_ch.rear_value  = rsp_rear_ff;

   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (count_ff == '0) && (head_ff == '0) && (tail_ff == '0))
      else $error("empty deque with stale pointers or count");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> (count_ff != '0) && (count_ff <= CNT_FULL))
      else $error("occupancy out of range for a nonempty deque");

   a_accept_to_resp: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == cdq_pkg::S_RESP))
      else $error("accepted request did not reach the response step");

   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cdq_pkg::S_RESP) && (status_ff != cdq_pkg::ST_DONE)
      |-> (count_ff == $past(count_ff)))
      else $error("refused request changed the occupancy");

   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_full_ff && rsp_empty_ff))
      else $error("response shows full and empty together");

endmodule
